FILE: src/tcte_pkg.sv
`default_nettype none

package tcte_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_COLUMNS,
		REG_ROWS,
		REG_CURSOR_COLUMN,
		REG_CURSOR_ROW
	} reg_index_t;

	// what follows the glyph of a cell
	typedef enum logic [1:0] {
		EOL_NONE,
		EOL_ROW,
		EOL_FRAME
	} eol_t;

	// one classified cell, handed from front to back
	typedef struct packed {
		logic       first;   // frame start: hide cursor and home first
		logic       sgr;     // colour escape needed
		logic [3:0] fg;
		logic [3:0] bg;
		logic       multi;   // three-byte utf-8 glyph
		logic [7:0] ch;      // single byte, or utf-8 lead byte
		logic [7:0] mid;
		logic [7:0] low;
		eol_t       eol;
	} cmd_t;

	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_LBR       = 8'h5B;
	localparam logic [7:0] CH_SEMI      = 8'h3B;
	localparam logic [7:0] CH_M         = 8'h6D;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_ONE       = 8'h31;
	localparam logic [7:0] CH_THREE     = 8'h33;
	localparam logic [7:0] CH_FOUR      = 8'h34;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TILDE_END = 8'h7F;
	localparam logic [7:0] CH_UTF8_LEAD = 8'hE2;

	// ESC[?25l ESC[H
	localparam logic [7:0] HIDE_HOME [9] = '{
		8'h1B, 8'h5B, 8'h3F, 8'h32, 8'h35, 8'h6C, 8'h1B, 8'h5B, 8'h48
	};
	// H ESC[?25h
	localparam logic [7:0] SHOW_TAIL [7] = '{
		8'h48, 8'h1B, 8'h5B, 8'h3F, 8'h32, 8'h35, 8'h68
	};

	// ansi colour digit for the low three bits of a vga colour index
	localparam logic [3:0] ANSI_DIGIT [8] = '{
		4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7
	};

	// {found, low byte of code point}; all translated glyphs sit in U+25xx
	function automatic logic [8:0] glyph_low(input logic [7:0] c);
		logic [8:0] g;
		case (c)
			8'hDB: g = {1'b1, 8'h88};
			8'hB0: g = {1'b1, 8'h91};
			8'hB1: g = {1'b1, 8'h92};
			8'hB2: g = {1'b1, 8'h93};
			8'd179: g = {1'b1, 8'h02};
			8'd196: g = {1'b1, 8'h00};
			8'd218: g = {1'b1, 8'h0C};
			8'd191: g = {1'b1, 8'h10};
			8'd192: g = {1'b1, 8'h14};
			8'd217: g = {1'b1, 8'h18};
			8'd195: g = {1'b1, 8'h1C};
			8'd180: g = {1'b1, 8'h24};
			8'd193: g = {1'b1, 8'h34};
			8'd194: g = {1'b1, 8'h2C};
			8'd197: g = {1'b1, 8'h3C};
			8'd186: g = {1'b1, 8'h51};
			8'd205: g = {1'b1, 8'h50};
			8'd201: g = {1'b1, 8'h54};
			8'd187: g = {1'b1, 8'h57};
			8'd200: g = {1'b1, 8'h5A};
			8'd188: g = {1'b1, 8'h5D};
			8'd204: g = {1'b1, 8'h60};
			8'd185: g = {1'b1, 8'h63};
			8'd202: g = {1'b1, 8'h69};
			8'd203: g = {1'b1, 8'h66};
			8'd206: g = {1'b1, 8'h6C};
			default: g = 9'd0;
		endcase
		return g;
	endfunction

	// {hundreds, tens, ones} of a value up to 256
	function automatic logic [11:0] dec3(input logic [8:0] v);
		logic [1:0] h;
		logic [8:0] r;
		logic [3:0] t;
		logic [8:0] o;
		h = (v >= 9'd200) ? 2'd2 : ((v >= 9'd100) ? 2'd1 : 2'd0);
		r = v - ((v >= 9'd200) ? 9'd200 : ((v >= 9'd100) ? 9'd100 : 9'd0));
		t = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (r >= 9'(10 * k)) t = t + 4'd1;
		end
		o = r - ({5'd0, t} * 9'd10);
		return {2'b00, h, t, o[3:0]};
	endfunction

endpackage

`default_nettype wire

FILE: src/tcte_front.sv
`default_nettype none

module tcte_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    char_code,
	input  wire logic [7:0]    attribute,
	input  wire logic [7:0]    columns,
	input  wire logic [7:0]    rows,
	output logic               cmd_valid,
	input  wire logic          cmd_ready,
	output tcte_pkg::cmd_t     cmd
);
	import tcte_pkg::*;

	logic [7:0] column_count_q;
	logic [7:0] row_count_q;
	logic [3:0] last_fg_q;
	logic [3:0] last_bg_q;
	logic       colour_valid_q;

	logic       accept;
	logic       first;
	logic       row_end;
	logic       frame_end;
	logic [3:0] fg;
	logic [3:0] bg;
	logic [8:0] glyph;

	assign s_tready  = cmd_ready;
	assign cmd_valid = s_tvalid;
	assign accept    = s_tvalid && cmd_ready;

	assign fg        = attribute[3:0];
	assign bg        = attribute[7:4];
	assign first     = (column_count_q == 8'd0) && (row_count_q == 8'd0);
	// saturating compares: a zero size acts like one
	assign row_end   = ({1'b0, column_count_q} + 9'd1) >= {1'b0, columns};
	assign frame_end = row_end && (({1'b0, row_count_q} + 9'd1) >= {1'b0, rows});
	assign glyph     = glyph_low(char_code);

	always_comb begin
		cmd.first = first;
		cmd.sgr   = first || !colour_valid_q || (fg != last_fg_q) || (bg != last_bg_q);
		cmd.fg    = fg;
		cmd.bg    = bg;
		cmd.multi = glyph[8];
		cmd.mid   = {2'b10, 4'h5, glyph[7:6]};
		cmd.low   = {2'b10, glyph[5:0]};
		if (glyph[8]) begin
			cmd.ch = CH_UTF8_LEAD;
		end else if ((char_code >= CH_SPACE) && (char_code < CH_TILDE_END)) begin
			cmd.ch = char_code;
		end else begin
			cmd.ch = CH_SPACE;
		end
		if (frame_end) begin
			cmd.eol = EOL_FRAME;
		end else if (row_end) begin
			cmd.eol = EOL_ROW;
		end else begin
			cmd.eol = EOL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= 8'd0;
			row_count_q    <= 8'd0;
			last_fg_q      <= 4'd0;
			last_bg_q      <= 4'd0;
			colour_valid_q <= 1'b0;
		end else if (accept) begin
			last_fg_q      <= fg;
			last_bg_q      <= bg;
			colour_valid_q <= 1'b1;
			if (row_end) begin
				column_count_q <= 8'd0;
				row_count_q    <= frame_end ? 8'd0 : row_count_q + 8'd1;
			end else begin
				column_count_q <= column_count_q + 8'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/tcte_queue.sv
`default_nettype none

module tcte_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tcte_pkg::cmd_t in_cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tcte_pkg::cmd_t     out_cmd
);
	import tcte_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/tcte_back.sv
`default_nettype none

module tcte_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire tcte_pkg::cmd_t cmd,
	input  wire logic [7:0]    cursor_column,
	input  wire logic [7:0]    cursor_row,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [7:0]         out_byte,
	output logic               last_of_cell,
	output logic               end_of_frame
);
	import tcte_pkg::*;

	typedef enum logic [3:0] {
		SEG_HOME,
		SEG_SGR_HEAD,
		SEG_SGR_BG,
		SEG_GLYPH,
		SEG_CRLF,
		SEG_CUR_HEAD,
		SEG_ROW_DEC,
		SEG_SEMI,
		SEG_COL_DEC,
		SEG_CUR_TAIL
	} seg_t;

	cmd_t       cmd_q;
	seg_t       seg_q;
	logic [3:0] idx_q;
	logic       busy_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       eof_q;

	logic [11:0] row_dig;
	logic [11:0] col_dig;
	logic [8:0]  row_v;
	logic [8:0]  col_v;
	logic [3:0]  row_start;
	logic [3:0]  col_start;
	logic [7:0]  byte_c;
	logic [3:0]  end_c;
	logic        more_c;
	seg_t        nseg_c;
	logic [3:0]  nstart_c;
	logic        adv;
	logic        seg_done;
	logic        cell_done;
	logic        load;

	assign row_v     = {1'b0, cursor_row} + 9'd1;
	assign col_v     = {1'b0, cursor_column} + 9'd1;
	assign row_dig   = dec3(row_v);
	assign col_dig   = dec3(col_v);
	// leading zeros are skipped by starting further into the digit segment
	assign row_start = (row_v >= 9'd100) ? 4'd0 : ((row_v >= 9'd10) ? 4'd1 : 4'd2);
	assign col_start = (col_v >= 9'd100) ? 4'd0 : ((col_v >= 9'd10) ? 4'd1 : 4'd2);

	always_comb begin
		case (seg_q)
			SEG_HOME: byte_c = HIDE_HOME[idx_q];
			SEG_SGR_HEAD: begin
				case (idx_q)
					4'd0: byte_c = CH_ESC;
					4'd1: byte_c = CH_LBR;
					4'd2: byte_c = cmd_q.fg[3] ? CH_NINE : CH_THREE;
					4'd3: byte_c = CH_ZERO | {4'd0, ANSI_DIGIT[cmd_q.fg[2:0]]};
					default: byte_c = CH_SEMI;
				endcase
			end
			SEG_SGR_BG: begin
				case (idx_q)
					4'd0: byte_c = CH_ONE;
					4'd1: byte_c = cmd_q.bg[3] ? CH_ZERO : CH_FOUR;
					4'd2: byte_c = CH_ZERO | {4'd0, ANSI_DIGIT[cmd_q.bg[2:0]]};
					default: byte_c = CH_M;
				endcase
			end
			SEG_GLYPH: begin
				case (idx_q)
					4'd0: byte_c = cmd_q.ch;
					4'd1: byte_c = cmd_q.mid;
					default: byte_c = cmd_q.low;
				endcase
			end
			SEG_CRLF: byte_c = (idx_q == 4'd0) ? CH_CR : CH_LF;
			SEG_CUR_HEAD: byte_c = (idx_q == 4'd0) ? CH_ESC : CH_LBR;
			SEG_ROW_DEC: begin
				case (idx_q)
					4'd0: byte_c = CH_ZERO | {4'd0, row_dig[11:8]};
					4'd1: byte_c = CH_ZERO | {4'd0, row_dig[7:4]};
					default: byte_c = CH_ZERO | {4'd0, row_dig[3:0]};
				endcase
			end
			SEG_SEMI: byte_c = CH_SEMI;
			SEG_COL_DEC: begin
				case (idx_q)
					4'd0: byte_c = CH_ZERO | {4'd0, col_dig[11:8]};
					4'd1: byte_c = CH_ZERO | {4'd0, col_dig[7:4]};
					default: byte_c = CH_ZERO | {4'd0, col_dig[3:0]};
				endcase
			end
			SEG_CUR_TAIL: byte_c = SHOW_TAIL[idx_q[2:0]];
			default: byte_c = CH_SPACE;
		endcase
	end

	// last index of the current segment and what comes after it
	always_comb begin
		more_c = 1'b1;
		nseg_c = SEG_GLYPH;
		end_c  = 4'd0;
		case (seg_q)
			SEG_HOME: begin
				end_c  = 4'd8;
				nseg_c = cmd_q.sgr ? SEG_SGR_HEAD : SEG_GLYPH;
			end
			SEG_SGR_HEAD: begin
				end_c  = 4'd4;
				nseg_c = SEG_SGR_BG;
			end
			SEG_SGR_BG: begin
				end_c  = 4'd3;
				nseg_c = SEG_GLYPH;
			end
			SEG_GLYPH: begin
				end_c = cmd_q.multi ? 4'd2 : 4'd0;
				case (cmd_q.eol)
					EOL_ROW: nseg_c = SEG_CRLF;
					EOL_FRAME: nseg_c = SEG_CUR_HEAD;
					default: more_c = 1'b0;
				endcase
			end
			SEG_CRLF: begin
				end_c  = 4'd1;
				more_c = 1'b0;
			end
			SEG_CUR_HEAD: begin
				end_c  = 4'd1;
				nseg_c = SEG_ROW_DEC;
			end
			SEG_ROW_DEC: begin
				end_c  = 4'd2;
				nseg_c = SEG_SEMI;
			end
			SEG_SEMI: begin
				end_c  = 4'd0;
				nseg_c = SEG_COL_DEC;
			end
			SEG_COL_DEC: begin
				end_c  = 4'd2;
				nseg_c = SEG_CUR_TAIL;
			end
			SEG_CUR_TAIL: begin
				end_c  = 4'd6;
				more_c = 1'b0;
			end
			default: more_c = 1'b0;
		endcase
		case (nseg_c)
			SEG_SGR_BG: nstart_c = cmd_q.bg[3] ? 4'd0 : 4'd1;
			SEG_ROW_DEC: nstart_c = row_start;
			SEG_COL_DEC: nstart_c = col_start;
			default: nstart_c = 4'd0;
		endcase
	end

	assign adv       = !valid_q || m_tready;
	assign seg_done  = idx_q == end_c;
	assign cell_done = busy_q && adv && seg_done && !more_c;
	// next cell is taken while the last beat of this one goes out
	assign load      = cmd_valid && (!busy_q || cell_done);
	assign cmd_ready = !busy_q || cell_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			if (adv) valid_q <= busy_q;
			if (load) begin
				busy_q <= 1'b1;
			end else if (cell_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			byte_q <= byte_c;
			last_q <= seg_done && !more_c;
			eof_q  <= seg_done && !more_c && (seg_q == SEG_CUR_TAIL);
		end
		if (load) begin
			cmd_q <= cmd;
			idx_q <= 4'd0;
			if (cmd.first) begin
				seg_q <= SEG_HOME;
			end else if (cmd.sgr) begin
				seg_q <= SEG_SGR_HEAD;
			end else begin
				seg_q <= SEG_GLYPH;
			end
		end else if (adv && busy_q) begin
			if (seg_done) begin
				seg_q <= nseg_c;
				idx_q <= nstart_c;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	assign m_tvalid     = valid_q;
	assign out_byte     = byte_q;
	assign last_of_cell = last_q;
	assign end_of_frame = eof_q;

endmodule

`default_nettype wire

FILE: src/text_cell_to_terminal_encoder_unit.sv
`default_nettype none

// channel   direction  beat payload
// s_*       in         tdata: char_code[7:0], attribute[15:8]
// m_*       out        tdata: out_byte[7:0]; tlast: last_of_cell; tuser: end_of_frame
// cfg_*     in         cfg_index: register, cfg_data: value
//
// the back end sends one output byte per cycle while a cell is pending and m_tready is high; a cell
// expands to 1 to 37 output bytes depending on escapes, utf-8 and row or frame end
// the front end takes one cell per cycle while the command queue has room
// reset clears the position counters, the remembered colour and the queue
// m_tready low stalls only the byte sequencer until the queue fills

module text_cell_to_terminal_encoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [15:0]           s_tdata,   // char_code, attribute
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // out_byte
	output logic                       m_tlast,   // last_of_cell
	output logic                       m_tuser,   // end_of_frame
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire tcte_pkg::reg_index_t  cfg_index,
	input  wire logic [7:0]            cfg_data
);
	import tcte_pkg::*;

	logic [7:0] columns_q;
	logic [7:0] rows_q;
	logic [7:0] cursor_column_q;
	logic [7:0] cursor_row_q;

	logic       f_valid;
	logic       f_ready;
	cmd_t       f_cmd;
	logic       b_valid;
	logic       b_ready;
	cmd_t       b_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q       <= 8'd80;
			rows_q          <= 8'd25;
			cursor_column_q <= 8'd0;
			cursor_row_q    <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_data;
				REG_ROWS: rows_q <= cfg_data;
				REG_CURSOR_COLUMN: cursor_column_q <= cfg_data;
				REG_CURSOR_ROW: cursor_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.char_code (s_tdata[7:0]),
		.attribute (s_tdata[15:8]),
		.columns   (columns_q),
		.rows      (rows_q),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	tcte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_cmd   (b_cmd)
	);

	tcte_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (b_valid),
		.cmd_ready     (b_ready),
		.cmd           (b_cmd),
		.cursor_column (cursor_column_q),
		.cursor_row    (cursor_row_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.out_byte      (m_tdata),
		.last_of_cell  (m_tlast),
		.end_of_frame  (m_tuser)
	);

endmodule

`default_nettype wire
